// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PIA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// Types, field widths and codes shared by the phase imbalance alarm monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pia_pkg;

  localparam int PHASE_W    = 21;  // per-phase power, signed
  localparam int TOTAL_W    = 23;  // total power and three-phase sum, signed
  localparam int TEMP_W     = 12;  // temperature, signed
  localparam int LIMIT_W    = 14;  // imbalance threshold, unsigned
  localparam int SUM_W      = 22;  // sum magnitude once known positive
  localparam int TRI_W      = 24;  // 3*Px - S, signed
  localparam int DEV_W      = 23;  // |3*Px - S|
  localparam int SCALED_W   = 36;  // limit * S
  localparam int NUM_ALARMS = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Sum below 10 W average: 3 phases * 100 tenths of a watt
  localparam logic signed [TOTAL_W-1:0] SUM_FLOOR = 23'sd300;
  localparam int unsigned               PERMILLE  = 1000;

  typedef enum logic [1:0] {
    OP_METER     = 2'd0,
    OP_TEMP      = 2'd1,
    OP_CLEAR_ONE = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } op_e;

  // Alarm selector codes for a clear-one command
  localparam logic [1:0] SEL_TEMP = 2'd0;
  localparam logic [1:0] SEL_IMB  = 2'd1;
  localparam logic [1:0] SEL_POW  = 2'd2;

  localparam logic [NUM_ALARMS-1:0] MASK_TEMP = 3'b001;
  localparam logic [NUM_ALARMS-1:0] MASK_IMB  = 3'b010;
  localparam logic [NUM_ALARMS-1:0] MASK_POW  = 3'b100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMBALANCE_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMBALANCE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT      = 3'd5;

  localparam logic signed [TEMP_W-1:0]  TEMP_LIMIT_RST      = 12'sd700;
  localparam logic [LIMIT_W-1:0]        IMBALANCE_LIMIT_RST = 14'd200;
  localparam logic signed [TOTAL_W-1:0] POWER_LIMIT_RST     = 23'sd30000;

  typedef struct packed {
    logic                      temp_enable;
    logic signed [TEMP_W-1:0]  temp_limit;
    logic                      imbalance_enable;
    logic [LIMIT_W-1:0]        imbalance_limit;
    logic                      power_enable;
    logic signed [TOTAL_W-1:0] power_limit;
  } cfg_t;

  typedef struct packed {
    op_e                       operation;
    logic                      reading_valid;
    logic signed [PHASE_W-1:0] phase_a_power;
    logic signed [PHASE_W-1:0] phase_b_power;
    logic signed [PHASE_W-1:0] phase_c_power;
    logic signed [TOTAL_W-1:0] total_power;
    logic signed [TEMP_W-1:0]  device_temp;
    logic [1:0]                alarm_select;
  } item_t;

  // Intermediate results between the measure and alarm stages
  typedef struct packed {
    op_e                 operation;
    logic                reading_valid;
    logic [1:0]          alarm_select;
    logic                sum_low;
    logic [SUM_W-1:0]    sum;
    logic [DEV_W-1:0]    max_dev;
    logic                power_over;
    logic                temp_over;
  } meas_t;

  typedef struct packed {
    logic [NUM_ALARMS-1:0] raised_mask;
    logic [NUM_ALARMS-1:0] cleared_mask;
    logic [NUM_ALARMS-1:0] active_mask;
    logic                  any_raised;
  } result_t;

endpackage

// File: src/pia_in_if.sv
// ----------------------------------------------------------------------------
// pia_in_if
// Input channel: one meter, temperature or clear transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pia_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic                               reading_valid;
  logic signed [pia_pkg::PHASE_W-1:0] phase_a_power;
  logic signed [pia_pkg::PHASE_W-1:0] phase_b_power;
  logic signed [pia_pkg::PHASE_W-1:0] phase_c_power;
  logic signed [pia_pkg::TOTAL_W-1:0] total_power;
  logic signed [pia_pkg::TEMP_W-1:0]  device_temp;
  logic [1:0]                         alarm_select;

  modport source (
    output valid, operation, reading_valid, phase_a_power, phase_b_power,
           phase_c_power, total_power, device_temp, alarm_select,
    input  ready
  );

  modport sink (
    input  valid, operation, reading_valid, phase_a_power, phase_b_power,
           phase_c_power, total_power, device_temp, alarm_select,
    output ready
  );
endinterface

// File: src/pia_out_if.sv
// ----------------------------------------------------------------------------
// pia_out_if
// Output channel: alarm masks produced by one input transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pia_out_if;
  logic                              valid;
  logic                              ready;
  logic [pia_pkg::NUM_ALARMS-1:0]    raised_mask;
  logic [pia_pkg::NUM_ALARMS-1:0]    cleared_mask;
  logic [pia_pkg::NUM_ALARMS-1:0]    active_mask;
  logic                              any_raised;

  modport source (
    output valid, raised_mask, cleared_mask, active_mask, any_raised,
    input  ready
  );

  modport sink (
    input  valid, raised_mask, cleared_mask, active_mask, any_raised,
    output ready
  );
endinterface

// File: src/pia_cfg_if.sv
// ----------------------------------------------------------------------------
// pia_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pia_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pia_pkg::CFG_IDX_W-1:0]     index;
  logic [pia_pkg::CFG_DATA_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: src/pia_cfg_regs.sv
// ----------------------------------------------------------------------------
// pia_cfg_regs
// Enable and threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pia_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  pia_cfg_if.sink         cfg_i,
  output pia_pkg::cfg_t   cfg_o
);

  pia_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pia_pkg::REG_TEMP_ENABLE:      cfg_d.temp_enable      = cfg_i.data[0];
        pia_pkg::REG_TEMP_LIMIT:       cfg_d.temp_limit       =
                                         cfg_i.data[pia_pkg::TEMP_W-1:0];
        pia_pkg::REG_IMBALANCE_ENABLE: cfg_d.imbalance_enable = cfg_i.data[0];
        pia_pkg::REG_IMBALANCE_LIMIT:  cfg_d.imbalance_limit  =
                                         cfg_i.data[pia_pkg::LIMIT_W-1:0];
        pia_pkg::REG_POWER_ENABLE:     cfg_d.power_enable     = cfg_i.data[0];
        pia_pkg::REG_POWER_LIMIT:      cfg_d.power_limit      =
                                         cfg_i.data[pia_pkg::TOTAL_W-1:0];
        default:                       cfg_d = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_enable      <= 1'b0;
      cfg_q.temp_limit       <= pia_pkg::TEMP_LIMIT_RST;
      cfg_q.imbalance_enable <= 1'b0;
      cfg_q.imbalance_limit  <= pia_pkg::IMBALANCE_LIMIT_RST;
      cfg_q.power_enable     <= 1'b0;
      cfg_q.power_limit      <= pia_pkg::POWER_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/pia_measure.sv
// ----------------------------------------------------------------------------
// pia_measure
// Phase sum, largest phase deviation and the threshold compares for
// temperature and total power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pia_measure (
  input  pia_pkg::item_t  item_i,
  input  pia_pkg::cfg_t   cfg_i,
  output pia_pkg::meas_t  meas_o
);

  logic signed [pia_pkg::TOTAL_W-1:0] sum;
  logic signed [pia_pkg::TRI_W-1:0]   sum_ext;
  logic [pia_pkg::DEV_W-1:0]          dev_a, dev_b, dev_c, dev_ab;

  // |3*p - s|, never near the negative limit for in-range fields
  function automatic logic [pia_pkg::DEV_W-1:0] phase_dev(
    input logic signed [pia_pkg::PHASE_W-1:0] p,
    input logic signed [pia_pkg::TRI_W-1:0]   s
  );
    logic signed [pia_pkg::TRI_W-1:0] p_ext;
    logic signed [pia_pkg::TRI_W-1:0] diff;
    logic signed [pia_pkg::TRI_W-1:0] mag;
    p_ext = {{(pia_pkg::TRI_W-pia_pkg::PHASE_W){p[pia_pkg::PHASE_W-1]}}, p};
    diff  = (p_ext <<< 1) + p_ext - s;
    mag   = diff[pia_pkg::TRI_W-1] ? -diff : diff;
    return mag[pia_pkg::DEV_W-1:0];
  endfunction

  always_comb begin
    sum = {{(pia_pkg::TOTAL_W-pia_pkg::PHASE_W){item_i.phase_a_power[pia_pkg::PHASE_W-1]}},
           item_i.phase_a_power}
        + {{(pia_pkg::TOTAL_W-pia_pkg::PHASE_W){item_i.phase_b_power[pia_pkg::PHASE_W-1]}},
           item_i.phase_b_power}
        + {{(pia_pkg::TOTAL_W-pia_pkg::PHASE_W){item_i.phase_c_power[pia_pkg::PHASE_W-1]}},
           item_i.phase_c_power};
    sum_ext = {sum[pia_pkg::TOTAL_W-1], sum};

    dev_a  = phase_dev(item_i.phase_a_power, sum_ext);
    dev_b  = phase_dev(item_i.phase_b_power, sum_ext);
    dev_c  = phase_dev(item_i.phase_c_power, sum_ext);
    dev_ab = (dev_b > dev_a) ? dev_b : dev_a;

    meas_o.operation     = item_i.operation;
    meas_o.reading_valid = item_i.reading_valid;
    meas_o.alarm_select  = item_i.alarm_select;
    meas_o.sum_low       = sum < pia_pkg::SUM_FLOOR;
    meas_o.sum           = sum[pia_pkg::SUM_W-1:0];
    meas_o.max_dev       = (dev_c > dev_ab) ? dev_c : dev_ab;
    meas_o.power_over    = item_i.total_power > cfg_i.power_limit;
    meas_o.temp_over     = item_i.device_temp > cfg_i.temp_limit;
  end

endmodule

// File: src/pia_alarm.sv
// ----------------------------------------------------------------------------
// pia_alarm
// Imbalance ratio compare and the latched alarm update: raise, clear on
// recheck, clear-one and clear-all commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pia_alarm (
  input  pia_pkg::meas_t                   meas_i,
  input  pia_pkg::cfg_t                    cfg_i,
  input  logic [pia_pkg::NUM_ALARMS-1:0]   active_i,
  output pia_pkg::result_t                 result_o
);

  logic [pia_pkg::SCALED_W-1:0]   dev_scaled;
  logic [pia_pkg::SCALED_W-1:0]   limit_scaled;
  logic                           imb_over;
  logic [pia_pkg::NUM_ALARMS-1:0] checked, exceeded, clear_mask;
  logic [pia_pkg::NUM_ALARMS-1:0] raised, cleared, active_next;

  always_comb begin
    // max|3Px - S| * 1000 > limit * S, valid only once S is known positive
    dev_scaled   = pia_pkg::SCALED_W'(meas_i.max_dev)
                 * pia_pkg::SCALED_W'(pia_pkg::PERMILLE);
    limit_scaled = pia_pkg::SCALED_W'(cfg_i.imbalance_limit)
                 * pia_pkg::SCALED_W'(meas_i.sum);
    imb_over     = !meas_i.sum_low && (dev_scaled > limit_scaled);

    checked    = '0;
    clear_mask = '0;
    exceeded   = {meas_i.power_over, imb_over, meas_i.temp_over};

    unique case (meas_i.operation)
      pia_pkg::OP_METER: begin
        if (meas_i.reading_valid) begin
          checked = (cfg_i.imbalance_enable ? pia_pkg::MASK_IMB : '0)
                  | (cfg_i.power_enable     ? pia_pkg::MASK_POW : '0);
        end
      end
      pia_pkg::OP_TEMP: begin
        if (meas_i.reading_valid && cfg_i.temp_enable) begin
          checked = pia_pkg::MASK_TEMP;
        end
      end
      pia_pkg::OP_CLEAR_ONE: begin
        unique case (meas_i.alarm_select)
          pia_pkg::SEL_TEMP: clear_mask = pia_pkg::MASK_TEMP;
          pia_pkg::SEL_IMB:  clear_mask = pia_pkg::MASK_IMB;
          pia_pkg::SEL_POW:  clear_mask = pia_pkg::MASK_POW;
          default:           clear_mask = '0;  // unknown selector clears nothing
        endcase
      end
      pia_pkg::OP_CLEAR_ALL: clear_mask = '1;
      default: begin
        checked    = '0;
        clear_mask = '0;
      end
    endcase

    // Raise only inactive alarms that exceed; drop active ones that no longer do
    raised      = checked & exceeded & ~active_i;
    cleared     = (checked & ~exceeded & active_i) | (clear_mask & active_i);
    active_next = (active_i | raised) & ~cleared;

    result_o.raised_mask  = raised;
    result_o.cleared_mask = cleared;
    result_o.active_mask  = active_next;
    result_o.any_raised   = |raised;
  end

endmodule

// File: src/phase_imbalance_alarm_monitor.sv
// ----------------------------------------------------------------------------
// phase_imbalance_alarm_monitor
// Latched temperature, phase imbalance and total power alarms.
//
//   channel  dir  fields
//   in_i     in   operation, reading_valid, phase_{a,b,c}_power,
//                 total_power, device_temp, alarm_select
//   out_o    out  raised_mask, cleared_mask, active_mask, any_raised
//   cfg_i    in   index, data (registers 0..5, other indexes ignored)
//
// One transaction per cycle sustained while the output is ready; each passes
// through the input register and then the result register. The phase sum,
// deviation, imbalance multiply and the alarm flag update all sit between the two.
// Reset loads the threshold defaults, clears all alarms and empties the pipe.
// On a stall a full stage holds unless an empty stage is after it; empty ones fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phase_imbalance_alarm_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  pia_in_if.sink     in_i,
  pia_out_if.source  out_o,
  pia_cfg_if.sink    cfg_i
);

  pia_pkg::cfg_t                  cfg;
  pia_pkg::item_t                 item_d, item_q;
  pia_pkg::meas_t                 meas;
  pia_pkg::result_t               res_d, res_q;
  logic [pia_pkg::NUM_ALARMS-1:0] alarm_d, alarm_q;
  logic                           v0_d, v0_q, v1_d, v1_q;
  logic                           ld0, ld1;

  pia_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pia_measure u_measure (
    .item_i (item_q),
    .cfg_i  (cfg),
    .meas_o (meas)
  );

  pia_alarm u_alarm (
    .meas_i   (meas),
    .cfg_i    (cfg),
    .active_i (alarm_q),
    .result_o (res_d)
  );

  // A stage loads when it is empty or its contents move on
  assign ld1 = !v1_q || out_o.ready;
  assign ld0 = !v0_q || ld1;

  assign in_i.ready = ld0;

  always_comb begin
    item_d.operation     = pia_pkg::op_e'(in_i.operation);
    item_d.reading_valid = in_i.reading_valid;
    item_d.phase_a_power = in_i.phase_a_power;
    item_d.phase_b_power = in_i.phase_b_power;
    item_d.phase_c_power = in_i.phase_c_power;
    item_d.total_power   = in_i.total_power;
    item_d.device_temp   = in_i.device_temp;
    item_d.alarm_select  = in_i.alarm_select;
  end

  always_comb begin
    v0_d    = ld0 ? in_i.valid : v0_q;
    v1_d    = ld1 ? v0_q : v1_q;
    alarm_d = (ld1 && v0_q) ? res_d.active_mask : alarm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      alarm_q <= '0;
    end else begin
      v0_q    <= v0_d;
      v1_q    <= v1_d;
      alarm_q <= alarm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0 && in_i.valid) begin
      item_q <= item_d;
    end
    if (ld1 && v0_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = v1_q;
  assign out_o.raised_mask  = res_q.raised_mask;
  assign out_o.cleared_mask = res_q.cleared_mask;
  assign out_o.active_mask  = res_q.active_mask;
  assign out_o.any_raised   = res_q.any_raised;

  `PIA_ASSERT_NEXT(a_state_tracks_result, ld1 && v0_q,
                   alarm_q == res_q.active_mask,
                   "alarm state differs from the reported active mask")
  `PIA_ASSERT_IMPL(a_raise_clear_disjoint, out_o.valid,
                   (out_o.raised_mask & out_o.cleared_mask) == 3'b000,
                   "alarm both raised and cleared by one transaction")
  `PIA_ASSERT_IMPL(a_masks_consistent, out_o.valid,
                   ((out_o.raised_mask & ~out_o.active_mask) == 3'b000) &&
                   ((out_o.cleared_mask & out_o.active_mask) == 3'b000),
                   "raised or cleared mask disagrees with active mask")
  `PIA_ASSERT_IMPL(a_any_raised, out_o.valid,
                   out_o.any_raised == (out_o.raised_mask != 3'b000),
                   "any_raised does not match raised_mask")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for phase_imbalance_alarm_monitor. Meter, temperature
// and clear transactions go in through a paced driver. A posedge monitor runs
// each accepted transaction through an alarm predictor and compares every
// result with the oldest prediction. Register settings change only while the
// pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pia_pkg::*;

  localparam int PIPE_DEPTH = 2;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 250;
  localparam longint PHASE_MAX = 1000000;
  localparam longint TOTAL_MAX = 3000000;
  localparam longint TEMP_MIN = -400;
  localparam longint TEMP_MAX = 2000;

  // Selector that names no alarm; register indexes past the last one
  localparam logic [1:0] SEL_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk_i;
  logic rst_ni;

  pia_in_if  in_if ();
  pia_out_if out_if ();
  pia_cfg_if cfg_if ();

  phase_imbalance_alarm_monitor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  item_t       pending_items[$];
  result_t     expected_masks[$];
  cfg_t        cfg_shadow;
  logic [2:0]  alarm_flags;
  int          n_sent;
  int          n_checked;
  int          n_errors;
  bit          calm;
  logic        in_taken;
  logic        cfg_taken;
  int          in_gap;
  int          out_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Alarm predictor
  // ---------------------------------------------------------------------------
  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void judge(input logic [2:0] flag, input bit over,
                                inout logic [2:0] up, inout logic [2:0] down);
    if (over) begin
      if ((alarm_flags & flag) == '0) begin
        alarm_flags = alarm_flags | flag;
        up = up | flag;
      end
    end else if ((alarm_flags & flag) != '0) begin
      alarm_flags = alarm_flags & ~flag;
      down = down | flag;
    end
  endfunction

  function automatic bit imbalance_over(input item_t it);
    longint a, b, c, s, m;
    a = longint'($signed(it.phase_a_power));
    b = longint'($signed(it.phase_b_power));
    c = longint'($signed(it.phase_c_power));
    s = a + b + c;
    // Average below 10 W counts as perfectly balanced
    if (s < longint'(SUM_FLOOR)) return 1'b0;
    m = magnitude(3 * a - s);
    if (magnitude(3 * b - s) > m) m = magnitude(3 * b - s);
    if (magnitude(3 * c - s) > m) m = magnitude(3 * c - s);
    return m * longint'(PERMILLE) > longint'(cfg_shadow.imbalance_limit) * s;
  endfunction

  function automatic result_t step_alarms(input item_t it);
    result_t    r;
    logic [2:0] up;
    logic [2:0] down;
    logic [2:0] sel_mask;
    up = '0;
    down = '0;
    sel_mask = '0;
    case (it.operation)
      OP_METER: begin
        if (it.reading_valid) begin
          if (cfg_shadow.imbalance_enable) judge(MASK_IMB, imbalance_over(it), up, down);
          if (cfg_shadow.power_enable) begin
            judge(MASK_POW, longint'($signed(it.total_power)) >
                  longint'(cfg_shadow.power_limit), up, down);
          end
        end
      end
      OP_TEMP: begin
        if (it.reading_valid && cfg_shadow.temp_enable) begin
          judge(MASK_TEMP, longint'($signed(it.device_temp)) >
                longint'(cfg_shadow.temp_limit), up, down);
        end
      end
      OP_CLEAR_ONE: begin
        case (it.alarm_select)
          SEL_TEMP: sel_mask = MASK_TEMP;
          SEL_IMB:  sel_mask = MASK_IMB;
          SEL_POW:  sel_mask = MASK_POW;
          default:  sel_mask = '0;
        endcase
        down = alarm_flags & sel_mask;
        alarm_flags = alarm_flags & ~sel_mask;
      end
      default: begin
        down = alarm_flags;
        alarm_flags = '0;
      end
    endcase
    r.raised_mask = up;
    r.cleared_mask = down;
    r.active_mask = alarm_flags;
    r.any_raised = (up != '0);
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TEMP_ENABLE:      cfg_shadow.temp_enable = data[0];
      REG_TEMP_LIMIT:       cfg_shadow.temp_limit = data[TEMP_W-1:0];
      REG_IMBALANCE_ENABLE: cfg_shadow.imbalance_enable = data[0];
      REG_IMBALANCE_LIMIT:  cfg_shadow.imbalance_limit = data[LIMIT_W-1:0];
      REG_POWER_ENABLE:     cfg_shadow.power_enable = data[0];
      REG_POWER_LIMIT:      cfg_shadow.power_limit = data[TOTAL_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic longint rand_span(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic longint fit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic item_t make_item(input op_e op, input logic vld,
                                      input longint a, input longint b,
                                      input longint c, input longint total,
                                      input longint temp, input logic [1:0] sel);
    item_t it;
    it.operation = op;
    it.reading_valid = vld;
    it.phase_a_power = PHASE_W'(a);
    it.phase_b_power = PHASE_W'(b);
    it.phase_c_power = PHASE_W'(c);
    it.total_power = TOTAL_W'(total);
    it.device_temp = TEMP_W'(temp);
    it.alarm_select = sel;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    longint      p, e, ph[3];
    int unsigned pick;
    int unsigned slot;
    // Fill every field so that unused ones toggle as well
    it = make_item(OP_METER, $urandom_range(0, 9) != 0,
                   rand_span(-PHASE_MAX, PHASE_MAX), rand_span(-PHASE_MAX, PHASE_MAX),
                   rand_span(-PHASE_MAX, PHASE_MAX), rand_span(-TOTAL_MAX, TOTAL_MAX),
                   rand_span(TEMP_MIN, TEMP_MAX), 2'($urandom_range(0, 3)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // One phase off by roughly the threshold distance, either side of it
        p = rand_span(0, 300000);
        e = p * longint'(cfg_shadow.imbalance_limit) * rand_span(100, 200) / 100000;
        if ($urandom_range(0, 1)) e = -e;
        for (int k = 0; k < 3; k++) ph[k] = p + rand_span(-3, 3);
        slot = $urandom_range(0, 2);
        ph[slot] = ph[slot] + e;
        it.phase_a_power = PHASE_W'(fit(ph[0], -PHASE_MAX, PHASE_MAX));
        it.phase_b_power = PHASE_W'(fit(ph[1], -PHASE_MAX, PHASE_MAX));
        it.phase_c_power = PHASE_W'(fit(ph[2], -PHASE_MAX, PHASE_MAX));
      end else if (pick < 8) begin
        // Sum close to the 10 W average floor
        p = rand_span(80, 120);
        it.phase_a_power = PHASE_W'(p + rand_span(-20, 20));
        it.phase_b_power = PHASE_W'(p + rand_span(-20, 20));
        it.phase_c_power = PHASE_W'(p + rand_span(-20, 20));
      end
      if ($urandom_range(0, 2) != 0) begin
        it.total_power = TOTAL_W'(fit(longint'(cfg_shadow.power_limit) + rand_span(-40, 40),
                                      -TOTAL_MAX, TOTAL_MAX));
      end
    end else if (pick < 75) begin
      it.operation = OP_TEMP;
      if ($urandom_range(0, 2) != 0) begin
        it.device_temp = TEMP_W'(fit(longint'(cfg_shadow.temp_limit) + rand_span(-15, 15),
                                     TEMP_MIN, TEMP_MAX));
      end
    end else if (pick < 90) begin
      it.operation = OP_CLEAR_ONE;
      it.alarm_select = ($urandom_range(0, 7) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
    end else begin
      it.operation = OP_CLEAR_ALL;
    end
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending_items.push_back(it);
    n_sent++;
  endtask

  task automatic queue_random(input int count);
    for (int k = 0; k < count; k++) queue_item(random_item());
  endtask

  // Called at a falling edge; returns at a falling edge with valid dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data <= val[CFG_DATA_W-1:0];
    cfg_if.valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_TEMP_ENABLE, longint'(c.temp_enable));
    write_reg(REG_TEMP_LIMIT, longint'(c.temp_limit));
    write_reg(REG_IMBALANCE_ENABLE, longint'(c.imbalance_enable));
    write_reg(REG_IMBALANCE_LIMIT, longint'(c.imbalance_limit));
    write_reg(REG_POWER_ENABLE, longint'(c.power_enable));
    write_reg(REG_POWER_LIMIT, longint'(c.power_limit));
  endtask

  // Hold until every prediction is matched, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk_i); while (n_checked != n_sent);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one transaction per valid, random gaps between them
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_items
    item_t nxt;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_if.operation <= nxt.operation;
        in_if.reading_valid <= nxt.reading_valid;
        in_if.phase_a_power <= nxt.phase_a_power;
        in_if.phase_b_power <= nxt.phase_b_power;
        in_if.phase_c_power <= nxt.phase_c_power;
        in_if.total_power <= nxt.total_power;
        in_if.device_temp <= nxt.device_temp;
        in_if.alarm_select <= nxt.alarm_select;
        in_if.valid <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 5);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure in bursts, none started once calm
  always @(negedge clk_i) begin : pace_results
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall = $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transactions, check on output transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    item_t   seen;
    result_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      cfg_taken <= cfg_if.valid && cfg_if.ready;
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        seen = make_item(op_e'(in_if.operation), in_if.reading_valid,
                         longint'(in_if.phase_a_power), longint'(in_if.phase_b_power),
                         longint'(in_if.phase_c_power), longint'(in_if.total_power),
                         longint'(in_if.device_temp), in_if.alarm_select);
        expected_masks.push_back(step_alarms(seen));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_masks.size() == 0) begin
          $error("unexpected result transaction");
          n_errors++;
        end else begin
          want = expected_masks.pop_front();
          if (out_if.raised_mask !== want.raised_mask) begin
            $error("raised_mask: expected %0h, got %0h", want.raised_mask, out_if.raised_mask);
            n_errors++;
          end
          if (out_if.cleared_mask !== want.cleared_mask) begin
            $error("cleared_mask: expected %0h, got %0h", want.cleared_mask,
                   out_if.cleared_mask);
            n_errors++;
          end
          if (out_if.active_mask !== want.active_mask) begin
            $error("active_mask: expected %0h, got %0h", want.active_mask, out_if.active_mask);
            n_errors++;
          end
          if (out_if.any_raised !== want.any_raised) begin
            $error("any_raised: expected %0h, got %0h", want.any_raised, out_if.any_raised);
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    cfg_t phase_cfgs[NUM_PHASES];

    in_if.valid = 1'b0;
    in_if.operation = OP_METER;
    in_if.reading_valid = 1'b0;
    in_if.phase_a_power = '0;
    in_if.phase_b_power = '0;
    in_if.phase_c_power = '0;
    in_if.total_power = '0;
    in_if.device_temp = '0;
    in_if.alarm_select = SEL_TEMP;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TEMP_ENABLE;
    cfg_if.data = '0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    calm = 1'b0;
    in_gap = 0;
    out_stall = 0;
    alarm_flags = '0;
    cfg_shadow.temp_enable = 1'b0;
    cfg_shadow.temp_limit = TEMP_LIMIT_RST;
    cfg_shadow.imbalance_enable = 1'b0;
    cfg_shadow.imbalance_limit = IMBALANCE_LIMIT_RST;
    cfg_shadow.power_enable = 1'b0;
    cfg_shadow.power_limit = POWER_LIMIT_RST;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every alarm disabled, nothing may rise
    queue_random(40);
    wait_idle();

    // Directed: all alarms on with default limits
    program_regs('{1'b1, TEMP_LIMIT_RST, 1'b1, IMBALANCE_LIMIT_RST, 1'b1, POWER_LIMIT_RST});
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, 701, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, 701, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, 700, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, TEMP_MAX, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b0, 0, 0, 0, 0, TEMP_MIN, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, TEMP_MIN, SEL_TEMP));
    // Imbalance and power exactly at their limits, then one step past
    queue_item(make_item(OP_METER, 1'b1, 1100, 1100, 800, 30000, 0, SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b1, 1101, 1101, 798, 30001, 0, SEL_TEMP));
    // Sum one below the floor, then right on it
    queue_item(make_item(OP_METER, 1'b1, PHASE_MAX, -PHASE_MAX, 299, TOTAL_MAX, 0,
                         SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b1, PHASE_MAX, -PHASE_MAX, 300, -TOTAL_MAX, 0,
                         SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b0, -PHASE_MAX, -PHASE_MAX, -PHASE_MAX, TOTAL_MAX, 0,
                         SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b1, -PHASE_MAX, -PHASE_MAX, -PHASE_MAX, TOTAL_MAX, 0,
                         SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b1, 1101, 1101, 798, 30001, 0, SEL_TEMP));
    queue_item(make_item(OP_TEMP, 1'b1, 0, 0, 0, 0, 1000, SEL_TEMP));
    queue_item(make_item(OP_CLEAR_ONE, 1'b1, 0, 0, 0, 0, 0, SEL_TEMP));
    queue_item(make_item(OP_CLEAR_ONE, 1'b1, 0, 0, 0, 0, 0, SEL_TEMP));
    queue_item(make_item(OP_CLEAR_ONE, 1'b1, 0, 0, 0, 0, 0, SEL_NONE));
    queue_item(make_item(OP_CLEAR_ONE, 1'b0, 0, 0, 0, 0, 0, SEL_IMB));
    queue_item(make_item(OP_CLEAR_ALL, 1'b1, 0, 0, 0, 0, 0, SEL_TEMP));
    queue_item(make_item(OP_METER, 1'b1, PHASE_MAX, PHASE_MAX, PHASE_MAX, TOTAL_MAX, 0,
                         SEL_TEMP));
    queue_item(make_item(OP_CLEAR_ALL, 1'b0, 0, 0, 0, 0, 0, SEL_POW));
    queue_item(make_item(OP_CLEAR_ONE, 1'b1, 0, 0, 0, 0, 0, SEL_POW));
    wait_idle();

    phase_cfgs[0] = '{1'b1, -12'sd400, 1'b1, 14'd0, 1'b1, -23'sd3000000};
    phase_cfgs[1] = '{1'b1, 12'sd2000, 1'b1, 14'd10000, 1'b1, 23'sd3000000};
    phase_cfgs[2] = '{1'b0, 12'sd250, 1'b1, 14'd150, 1'b1, 23'sd0};
    phase_cfgs[3] = '{1'b1, 12'sd900, 1'b0, 14'd16383, 1'b0, -23'sd12345};
    phase_cfgs[4] = '{1'b1, 12'(rand_span(TEMP_MIN, TEMP_MAX)), 1'b1,
                      14'($urandom_range(50, 1000)), 1'b1,
                      23'(rand_span(-TOTAL_MAX, TOTAL_MAX))};

    for (int k = 0; k < NUM_PHASES; k++) begin
      program_regs(phase_cfgs[k]);
      if (k == 2) begin
        // Writes past the last register must leave the settings alone
        write_reg(REG_SPARE_6, 1);
        write_reg(REG_SPARE_7, -1);
      end
      if (k == NUM_PHASES - 1) calm = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (PIPE_DEPTH + 5) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/pia_pkg.sv
src/pia_in_if.sv
src/pia_out_if.sv
src/pia_cfg_if.sv
src/pia_cfg_regs.sv
src/pia_measure.sv
src/pia_alarm.sv
src/phase_imbalance_alarm_monitor.sv
tb/tb_top.sv
